// File: src/stream_health_monitor_assert.svh
`ifndef STREAM_HEALTH_MONITOR_ASSERT_SVH
`define STREAM_HEALTH_MONITOR_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define SHM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SHM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/shm_pkg.sv
`timescale 1ns / 1ps

package shm_pkg;

  localparam int unsigned MAX_ARRIVALS_DEF = 64;
  localparam int unsigned TIME_BITS_DEF    = 48;

  localparam logic [63:0] RATE_NUM      = 64'd1000000000;
  localparam logic [63:0] WINDOW_NUM    = 64'd10000000000;
  localparam logic [31:0] MIN_WINDOW_US = 32'd1000000;
  localparam logic [19:0] RATE_MAX      = 20'hFFFFF;

  localparam logic [19:0] EXP_RATE_RST  = 20'd10000;
  localparam logic [15:0] RATIO_RST     = 16'd128;
  localparam logic [31:0] TIMEOUT_RST   = 32'd1000000;
  localparam logic [23:0] MIN_PTS_RST   = 24'd0;

  localparam logic [1:0] REG_EXP_RATE = 2'd0;
  localparam logic [1:0] REG_RATIO    = 2'd1;
  localparam logic [1:0] REG_TIMEOUT  = 2'd2;
  localparam logic [1:0] REG_MIN_PTS  = 2'd3;

  localparam logic CMD_ARRIVAL = 1'b0;
  localparam logic CMD_QUERY   = 1'b1;

  localparam logic [2:0] ST_NO_DATA   = 3'd0;
  localparam logic [2:0] ST_STREAMING = 3'd1;
  localparam logic [2:0] ST_TIMEOUT   = 3'd2;
  localparam logic [2:0] ST_SPARSE    = 3'd3;
  localparam logic [2:0] ST_RATE_LOW  = 3'd4;

  localparam logic [1:0] LVL_STALE = 2'd0;
  localparam logic [1:0] LVL_OK    = 2'd1;
  localparam logic [1:0] LVL_WARN  = 2'd2;
  localparam logic [1:0] LVL_ERROR = 2'd3;

endpackage

// File: src/shm_div.sv
`timescale 1ns / 1ps

module shm_div import shm_pkg::*; #(
  parameter int unsigned DVD_W = 36,
  parameter int unsigned DVS_W = 48
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [DVD_W-1:0] quotient_o
);

  localparam int unsigned CNT_W = $clog2(DVD_W + 1);

  logic [DVS_W-1:0] rem_q, rem_d, dvs_q;
  logic [DVD_W-1:0] quo_q, quo_d;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;
  logic [DVS_W:0]   trial, diff;
  logic             ge;

  // one quotient bit per cycle
  always_comb begin
    trial = {rem_q, quo_q[DVD_W-1]};
    ge    = trial >= {1'b0, dvs_q};
    diff  = trial - {1'b0, dvs_q};
    rem_d = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
    quo_d = {quo_q[DVD_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CNT_W'(DVD_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// File: src/shm_ring.sv
`timescale 1ns / 1ps

module shm_ring import shm_pkg::*; #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 48,
  parameter int unsigned AW    = 6
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/stream_health_monitor.sv
`timescale 1ns / 1ps
// channel   | dir | handshake                 | payload
// s_axis    | in  | s_axis_tvalid/tready      | tuser cmd, tdata time_us, points
// m_axis    | out | m_axis_tvalid/tready      | tdata status .. cloud_total
// apb       | in  | psel/penable/pwrite/pready| paddr, pwdata, prdata
// an arrival runs the bit-serial window divide, writes the ring, then drops stored ring entries
// that fall outside the window
// a query with two or more stored times makes two ring reads and, when the span is positive,
// the bit-serial rate divide; a query without that goes straight to S_FIN
// one item at a time; s_axis_tready is high only while no item is at work
// the result register lets the next item in while a result waits on m_axis_tready
// rst_ni clears control and configuration; ring contents are not cleared

`include "stream_health_monitor_assert.svh"

module stream_health_monitor import shm_pkg::*; #(
  parameter int unsigned MAX_ARRIVALS = MAX_ARRIVALS_DEF,
  parameter int unsigned TIME_BITS    = TIME_BITS_DEF,
  localparam int unsigned IN_W  = ((TIME_BITS + 24 + 7) / 8) * 8,
  localparam int unsigned OUT_W = ((TIME_BITS + 82 + 7) / 8) * 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [IN_W-1:0]  s_axis_tdata,  // time_us, points
  input  logic             s_axis_tuser,  // cmd
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [OUT_W-1:0] m_axis_tdata,  // status, level, data flag, age_us, rate_mhz,
                                          // last points, cloud_total
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [3:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int unsigned PTR_W  = $clog2(MAX_ARRIVALS);
  localparam int unsigned FILL_W = $clog2(MAX_ARRIVALS + 1);
  localparam int unsigned QW     = $clog2(MAX_ARRIVALS) + 30;
  localparam int unsigned DVD_W  = (QW > 34) ? QW : 34;
  localparam int unsigned CMP_W  = (TIME_BITS > DVD_W) ? TIME_BITS : DVD_W;

  typedef enum logic [3:0] {
    S_IDLE, S_WDIV, S_WRITE, S_DRD, S_DCHK,
    S_QRD_OLD, S_QRD_NEW, S_QSPAN, S_QDIV, S_FIN
  } state_e;

  state_e state_q;

  logic [19:0] exp_q;
  logic [15:0] ratio_q;
  logic [31:0] timeout_q;
  logic [23:0] min_pts_q;
  logic [35:0] thr_q;

  logic [PTR_W-1:0]     head_q;
  logic [FILL_W-1:0]    fill_q;
  logic [TIME_BITS-1:0] last_arr_q, now_q, age_q, oldest_q;
  logic [23:0]          last_pts_q;
  logic                 seen_q;
  logic [31:0]          total_q;
  logic [DVD_W-1:0]     window_q;
  logic [19:0]          rate_q;

  logic                 out_valid_q;
  logic [2:0]           o_status_q;
  logic [1:0]           o_level_q;
  logic                 o_has_q;
  logic [TIME_BITS-1:0] o_age_q;
  logic [19:0]          o_rate_q;
  logic [23:0]          o_pts_q;
  logic [31:0]          o_total_q;

  logic                 in_acc, cfg_wr;
  logic [TIME_BITS-1:0] in_time;
  logic [23:0]          in_pts;
  logic                 div_start, div_busy, div_done;
  logic [DVD_W-1:0]     div_dvd, div_q;
  logic [TIME_BITS-1:0] div_dvs;
  logic                 ring_we;
  logic [PTR_W-1:0]     ring_waddr, ring_raddr;
  logic [TIME_BITS-1:0] ring_rdata, top;
  logic [TIME_BITS-1:0] drop_diff;
  logic                 out_free;
  logic [2:0]           fin_status;
  logic [1:0]           fin_level;

  function automatic logic [PTR_W-1:0] wrap(input logic [PTR_W-1:0] base,
                                            input logic [FILL_W-1:0] off);
    logic [FILL_W:0] s;
    s = (FILL_W + 1)'(base) + (FILL_W + 1)'(off);
    if (s >= (FILL_W + 1)'(MAX_ARRIVALS)) begin
      s = s - (FILL_W + 1)'(MAX_ARRIVALS);
    end
    return s[PTR_W-1:0];
  endfunction

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign in_time  = s_axis_tdata[TIME_BITS-1:0];
  assign in_pts   = s_axis_tdata[TIME_BITS+23:TIME_BITS];
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign pready   = 1'b1;
  assign out_free = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);

  always_comb begin
    case (paddr[3:2])
      REG_EXP_RATE: prdata = 32'(exp_q);
      REG_RATIO:    prdata = 32'(ratio_q);
      REG_TIMEOUT:  prdata = timeout_q;
      REG_MIN_PTS:  prdata = 32'(min_pts_q);
      default:      prdata = '0;
    endcase
  end

  always_comb begin
    top       = (now_q > ring_rdata) ? now_q : ring_rdata;
    div_dvd   = DVD_W'(WINDOW_NUM);
    div_dvs   = TIME_BITS'(exp_q);
    div_start = 1'b0;
    if (state_q == S_IDLE && in_acc && s_axis_tuser == CMD_ARRIVAL) begin
      div_start = 1'b1;
    end else if (state_q == S_QSPAN && top > oldest_q) begin
      div_start = 1'b1;
      div_dvd   = DVD_W'(fill_q - FILL_W'(1)) * DVD_W'(RATE_NUM);
      div_dvs   = top - oldest_q;
    end
  end

  shm_div #(.DVD_W(DVD_W), .DVS_W(TIME_BITS)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  always_comb begin
    ring_we    = (state_q == S_WRITE);
    ring_waddr = (fill_q >= FILL_W'(MAX_ARRIVALS)) ? head_q : wrap(head_q, fill_q);
    case (state_q)
      S_QRD_NEW: ring_raddr = wrap(head_q, fill_q - FILL_W'(1));
      default:   ring_raddr = head_q;
    endcase
  end

  shm_ring #(.DEPTH(MAX_ARRIVALS), .WIDTH(TIME_BITS), .AW(PTR_W)) u_ring (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (ring_waddr),
    .wdata_i (now_q),
    .raddr_i (ring_raddr),
    .rdata_o (ring_rdata)
  );

  assign drop_diff = now_q - ring_rdata;

  always_comb begin
    if (!seen_q) begin
      fin_status = ST_NO_DATA;
      fin_level  = LVL_STALE;
    end else if (age_q > TIME_BITS'(timeout_q)) begin
      fin_status = ST_TIMEOUT;
      fin_level  = LVL_ERROR;
    end else if (last_pts_q < min_pts_q) begin
      fin_status = ST_SPARSE;
      fin_level  = LVL_WARN;
    end else if (fill_q >= FILL_W'(2) && {8'd0, rate_q, 8'd0} < thr_q) begin
      fin_status = ST_RATE_LOW;
      fin_level  = LVL_WARN;
    end else begin
      fin_status = ST_STREAMING;
      fin_level  = LVL_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      exp_q       <= EXP_RATE_RST;
      ratio_q     <= RATIO_RST;
      timeout_q   <= TIMEOUT_RST;
      min_pts_q   <= MIN_PTS_RST;
      head_q      <= '0;
      fill_q      <= '0;
      last_arr_q  <= '0;
      last_pts_q  <= '0;
      seen_q      <= 1'b0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (paddr[3:2])
          REG_EXP_RATE: exp_q     <= (pwdata[19:0] == '0) ? 20'd1 : pwdata[19:0];
          REG_RATIO:    ratio_q   <= (pwdata[15:0] == '0) ? 16'd1 : pwdata[15:0];
          REG_TIMEOUT:  timeout_q <= (pwdata == '0) ? 32'd1 : pwdata;
          REG_MIN_PTS:  min_pts_q <= pwdata[23:0];
          default:      ;
        endcase
      end
      if (state_q == S_FIN && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            if (s_axis_tuser == CMD_ARRIVAL) begin
              last_arr_q <= in_time;
              last_pts_q <= in_pts;
              seen_q     <= 1'b1;
              if (total_q != '1) begin
                total_q <= total_q + 32'd1;
              end
              state_q <= S_WDIV;
            end else if (!seen_q || fill_q < FILL_W'(2)) begin
              state_q <= S_FIN;
            end else begin
              state_q <= S_QRD_OLD;
            end
          end
        end
        S_WDIV: begin
          if (div_done) begin
            state_q <= S_WRITE;
          end
        end
        S_WRITE: begin
          if (fill_q >= FILL_W'(MAX_ARRIVALS)) begin
            head_q <= wrap(head_q, FILL_W'(1));
          end else begin
            fill_q <= fill_q + FILL_W'(1);
          end
          state_q <= S_DRD;
        end
        S_DRD: begin
          state_q <= (fill_q > FILL_W'(1)) ? S_DCHK : S_IDLE;
        end
        S_DCHK: begin
          if (now_q > ring_rdata && CMP_W'(drop_diff) > CMP_W'(window_q)) begin
            head_q  <= wrap(head_q, FILL_W'(1));
            fill_q  <= fill_q - FILL_W'(1);
            state_q <= S_DRD;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_QRD_OLD: state_q <= S_QRD_NEW;
        S_QRD_NEW: state_q <= S_QSPAN;
        S_QSPAN:   state_q <= (top > oldest_q) ? S_QDIV : S_FIN;
        S_QDIV: begin
          if (div_done) begin
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    thr_q <= 36'(exp_q) * 36'(ratio_q);
    if (state_q == S_IDLE && in_acc) begin
      now_q  <= in_time;
      age_q  <= (in_time > last_arr_q) ? in_time - last_arr_q : '0;
      rate_q <= '0;
    end
    if (state_q == S_WDIV && div_done) begin
      window_q <= (div_q < DVD_W'(MIN_WINDOW_US)) ? DVD_W'(MIN_WINDOW_US) : div_q;
    end
    if (state_q == S_QRD_NEW) begin
      oldest_q <= ring_rdata;
    end
    if (state_q == S_QDIV && div_done) begin
      rate_q <= (|div_q[DVD_W-1:20]) ? RATE_MAX : div_q[19:0];
    end
    if (state_q == S_FIN && out_free) begin
      o_status_q <= fin_status;
      o_level_q  <= fin_level;
      o_has_q    <= seen_q;
      o_age_q    <= seen_q ? age_q : '0;
      o_rate_q   <= seen_q ? rate_q : '0;
      o_pts_q    <= seen_q ? last_pts_q : '0;
      o_total_q  <= total_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_W'({o_total_q, o_pts_q, o_rate_q, o_age_q,
                                 o_has_q, o_level_q, o_status_q});

  `SHM_ASSERT_IMP(a_fill_range, 1'b1, fill_q <= FILL_W'(MAX_ARRIVALS), "ring fill above depth")
  `SHM_ASSERT_IMP(a_div_free, div_start, !div_busy, "divider started while busy")
  `SHM_ASSERT_NEXT(a_item_leaves_idle, in_acc, state_q != S_IDLE, "accepted item not worked")

endmodule
